// ===== rtl/core/bearing_angle_atan2_defines.svh =====
// ---------------------------------------------------------------------------
// Bearing angle assertion macros
// Concurrent assertion wrappers for the bearing angle core. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BEARING_ANGLE_ATAN2_DEFINES_SVH
`define BEARING_ANGLE_ATAN2_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define BAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define BAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/bat_pkg.sv =====
// ---------------------------------------------------------------------------
// Bearing angle package
// Shared widths, types and the elaboration-time arctangent table builder.
// ---------------------------------------------------------------------------
`default_nettype none

package bat_pkg;

  localparam int COORD_WIDTH_DEF   = 32;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Internal angles are fractions of a turn, one turn = 2^TURN_BITS.
  localparam int TURN_BITS = 48;
  // The larger magnitude is normalized so that its top bit lands here.
  localparam int NORM_TOP  = 59;
  localparam int CORDIC_W  = 63;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  typedef logic [TURN_BITS-1:0]       turn_t;
  typedef logic signed [CORDIC_W-1:0] cword_t;

  typedef struct packed {
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } bat_case_t;

  // Restoring long division, used only while building constants.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-idx) in turn units: truncating series in Q60, then long
  // division by 2*pi, one quotient bit per step.
  function automatic turn_t atan_turns(input int unsigned idx);
    logic [63:0] rad;
    logic [63:0] q;
    logic [63:0] term;
    int unsigned sh;
    logic        done;
    rad  = '0;
    q    = '0;
    term = '0;
    sh   = 0;
    done = 1'b0;
    if (idx == 0) begin
      q = 64'd1 << (TURN_BITS - 3);
    end else begin
      for (int k = 0; k < 64; k++) begin
        sh = idx * 32'(2 * k + 1);
        if (sh >= 61) begin
          done = 1'b1;
        end
        if (!done) begin
          term = udiv64(64'd1 << (60 - sh), 64'(2 * k + 1));
          if (k[0]) begin
            rad = rad - term;
          end else begin
            rad = rad + term;
          end
        end
      end
      for (int b = 0; b < TURN_BITS; b++) begin
        rad = rad << 1;
        q   = q << 1;
        if (rad >= TWO_PI_Q60) begin
          rad  = rad - TWO_PI_Q60;
          q[0] = 1'b1;
        end
      end
    end
    return q[TURN_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bat_front.sv =====
// ---------------------------------------------------------------------------
// Bearing angle front end
// Two stages: full-width coordinate differences, then magnitudes and the
// sign and zero flags that later select the quadrant.
// ---------------------------------------------------------------------------
`default_nettype none

module bat_front #(
  parameter int COORD_WIDTH = bat_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] target_y,
  input  logic signed [COORD_WIDTH-1:0] target_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_ax,
  output logic [COORD_WIDTH-1:0]        out_ay,
  output bat_pkg::bat_case_t            out_case
);

  localparam int DW = COORD_WIDTH + 1;

  logic                   v1_r, v2_r;
  logic                   en1, en2;
  logic [DW-1:0]          dx_nxt, dy_nxt, dx_r, dy_r;
  logic [DW-1:0]          ndx, ndy;
  logic [COORD_WIDTH-1:0] ax_nxt, ay_nxt, ax_r, ay_r;
  bat_pkg::bat_case_t     cs_nxt, cs_r;

  // Each stage loads when it is empty or its item moves on.
  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign dx_nxt = {target_x[COORD_WIDTH-1], target_x} - {origin_x[COORD_WIDTH-1], origin_x};
  assign dy_nxt = {target_y[COORD_WIDTH-1], target_y} - {origin_y[COORD_WIDTH-1], origin_y};

  // A difference never reaches 2^COORD_WIDTH in magnitude.
  assign ndx    = '0 - dx_r;
  assign ndy    = '0 - dy_r;
  assign ax_nxt = dx_r[DW-1] ? ndx[COORD_WIDTH-1:0] : dx_r[COORD_WIDTH-1:0];
  assign ay_nxt = dy_r[DW-1] ? ndy[COORD_WIDTH-1:0] : dy_r[COORD_WIDTH-1:0];

  always_comb begin
    cs_nxt.dx_zero = (dx_r == '0);
    cs_nxt.dy_zero = (dy_r == '0);
    cs_nxt.dx_neg  = dx_r[DW-1];
    cs_nxt.dy_neg  = dy_r[DW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (en2) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      cs_r <= cs_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_ax    = ax_r;
  assign out_ay    = ay_r;
  assign out_case  = cs_r;

endmodule

`default_nettype wire

// ===== rtl/core/bat_norm.sv =====
// ---------------------------------------------------------------------------
// Bearing angle normalizer
// Pipelined leading-zero normalization of the magnitude pair: each stage
// tries one power-of-two shift, largest first, so the larger magnitude ends
// with its top bit at the top of the word.
// ---------------------------------------------------------------------------
`default_nettype none

module bat_norm #(
  parameter int COORD_WIDTH = bat_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] in_ax,
  input  logic [COORD_WIDTH-1:0] in_ay,
  input  bat_pkg::bat_case_t     in_case,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COORD_WIDTH-1:0] out_ax,
  output logic [COORD_WIDTH-1:0] out_ay,
  output bat_pkg::bat_case_t     out_case
);

  localparam int NSTEPS = $clog2(COORD_WIDTH);

  logic [COORD_WIDTH-1:0] ax_s [0:NSTEPS];
  logic [COORD_WIDTH-1:0] ay_s [0:NSTEPS];
  bat_pkg::bat_case_t     cs_s [0:NSTEPS];
  logic [NSTEPS:0]        v_s;
  logic [NSTEPS:0]        rdy_s;

  assign v_s[0]        = in_valid;
  assign ax_s[0]       = in_ax;
  assign ay_s[0]       = in_ay;
  assign cs_s[0]       = in_case;
  assign rdy_s[NSTEPS] = out_ready;
  assign in_ready      = rdy_s[0];

  for (genvar t = 0; t < NSTEPS; t++) begin : g_step
    localparam int SH = 1 << (NSTEPS - 1 - t);

    logic                   v_r;
    logic                   en;
    logic                   hit;
    logic [COORD_WIDTH-1:0] m;
    logic [COORD_WIDTH-1:0] ax_nxt, ay_nxt, ax_r, ay_r;
    bat_pkg::bat_case_t     cs_r;

    assign en         = !v_r || rdy_s[t+1];
    assign rdy_s[t]   = en;
    assign m          = ax_s[t] | ay_s[t];
    assign hit        = (m[COORD_WIDTH-1 -: SH] == '0);
    assign ax_nxt     = hit ? (ax_s[t] << SH) : ax_s[t];
    assign ay_nxt     = hit ? (ay_s[t] << SH) : ay_s[t];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ax_r <= ax_nxt;
        ay_r <= ay_nxt;
        cs_r <= cs_s[t];
      end
    end

    assign v_s[t+1]  = v_r;
    assign ax_s[t+1] = ax_r;
    assign ay_s[t+1] = ay_r;
    assign cs_s[t+1] = cs_r;
  end

  assign out_valid = v_s[NSTEPS];
  assign out_ax    = ax_s[NSTEPS];
  assign out_ay    = ay_s[NSTEPS];
  assign out_case  = cs_s[NSTEPS];

endmodule

`default_nettype wire

// ===== rtl/core/bat_cordic.sv =====
// ---------------------------------------------------------------------------
// Bearing angle CORDIC
// Unrolled vectoring CORDIC, one micro-rotation per register stage, that
// accumulates the first-quadrant angle of the normalized magnitudes.
// ---------------------------------------------------------------------------
`default_nettype none

module bat_cordic #(
  parameter int COORD_WIDTH   = bat_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES = bat_pkg::CORDIC_STAGES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [COORD_WIDTH-1:0] in_ax,
  input  logic [COORD_WIDTH-1:0] in_ay,
  input  bat_pkg::bat_case_t     in_case,
  output logic                   out_valid,
  input  logic                   out_ready,
  output bat_pkg::turn_t         out_z,
  output bat_pkg::bat_case_t     out_case
);

  localparam int PAD_LO = bat_pkg::NORM_TOP + 1 - COORD_WIDTH;
  localparam int PAD_HI = bat_pkg::CORDIC_W - bat_pkg::NORM_TOP - 1;

  bat_pkg::cword_t    x_s  [0:CORDIC_STAGES-1];
  bat_pkg::cword_t    y_s  [0:CORDIC_STAGES-1];
  bat_pkg::turn_t     z_s  [0:CORDIC_STAGES];
  bat_pkg::bat_case_t cs_s [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0] v_s;
  logic [CORDIC_STAGES:0] rdy_s;

  // Place the normalized magnitudes with their top bit at NORM_TOP.
  assign x_s[0]  = {{PAD_HI{1'b0}}, in_ax, {PAD_LO{1'b0}}};
  assign y_s[0]  = {{PAD_HI{1'b0}}, in_ay, {PAD_LO{1'b0}}};
  assign z_s[0]  = '0;
  assign cs_s[0] = in_case;
  assign v_s[0]  = in_valid;
  assign rdy_s[CORDIC_STAGES] = out_ready;
  assign in_ready = rdy_s[0];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam bat_pkg::turn_t ATAN = bat_pkg::atan_turns(i);

    logic               v_r;
    logic               en;
    logic               neg;
    bat_pkg::turn_t     z_nxt, z_r;
    bat_pkg::bat_case_t cs_r;

    assign en       = !v_r || rdy_s[i+1];
    assign rdy_s[i] = en;
    assign neg      = y_s[i][bat_pkg::CORDIC_W-1];
    assign z_nxt    = neg ? (z_s[i] - ATAN) : (z_s[i] + ATAN);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        z_r  <= z_nxt;
        cs_r <= cs_s[i];
      end
    end

    assign v_s[i+1]  = v_r;
    assign z_s[i+1]  = z_r;
    assign cs_s[i+1] = cs_r;

    // The last stage needs only the angle.
    if (i < CORDIC_STAGES - 1) begin : g_xy
      bat_pkg::cword_t xs, ys, x_nxt, y_nxt, x_r, y_r;

      assign xs    = x_s[i] >>> i;
      assign ys    = y_s[i] >>> i;
      assign x_nxt = neg ? (x_s[i] - ys) : (x_s[i] + ys);
      assign y_nxt = neg ? (y_s[i] + xs) : (y_s[i] - xs);

      always_ff @(posedge clk) begin
        if (en) begin
          x_r <= x_nxt;
          y_r <= y_nxt;
        end
      end

      assign x_s[i+1] = x_r;
      assign y_s[i+1] = y_r;
    end
  end

  assign out_valid = v_s[CORDIC_STAGES];
  assign out_z     = z_s[CORDIC_STAGES];
  assign out_case  = cs_s[CORDIC_STAGES];

endmodule

`default_nettype wire

// ===== rtl/core/bat_back.sv =====
// ---------------------------------------------------------------------------
// Bearing angle back end
// Clamps the first-quadrant angle, maps it to the full circle from difference
// signs and zero flags and rounds it to the output width in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module bat_back #(
  parameter int ANGLE_WIDTH = bat_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bat_pkg::turn_t         in_z,
  input  bat_pkg::bat_case_t     in_case,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [ANGLE_WIDTH-1:0] out_bearing
);

  localparam int             TB      = bat_pkg::TURN_BITS;
  localparam bat_pkg::turn_t QUARTER = bat_pkg::turn_t'(1) << (TB - 2);
  localparam bat_pkg::turn_t HALF    = bat_pkg::turn_t'(1) << (TB - 1);
  localparam bat_pkg::turn_t RND     = bat_pkg::turn_t'(1) << (TB - ANGLE_WIDTH - 1);

  logic                   va_r, vb_r, vc_r;
  logic                   ena, enb, enc;
  bat_pkg::turn_t         a_nxt, a_r, z_nxt, z_r, zsum;
  bat_pkg::bat_case_t     csa_r;
  logic [ANGLE_WIDTH-1:0] bearing_nxt, bearing_r;

  assign enc      = !vc_r || out_ready;
  assign enb      = !vb_r || enc;
  assign ena      = !va_r || enb;
  assign in_ready = ena;

  // A slightly negative accumulator clamps to zero, an overshoot to a quarter turn.
  always_comb begin
    if (in_z[TB-1]) begin
      a_nxt = '0;
    end else if (in_z > QUARTER) begin
      a_nxt = QUARTER;
    end else begin
      a_nxt = in_z;
    end
  end

  always_comb begin
    priority if (csa_r.dx_zero && csa_r.dy_zero) begin
      z_nxt = '0;
    end else if (csa_r.dx_zero) begin
      z_nxt = csa_r.dy_neg ? (HALF + QUARTER) : QUARTER;
    end else if (csa_r.dy_zero) begin
      z_nxt = csa_r.dx_neg ? HALF : '0;
    end else if (!csa_r.dx_neg && !csa_r.dy_neg) begin
      z_nxt = a_r;
    end else if (!csa_r.dy_neg) begin
      z_nxt = HALF - a_r;
    end else if (csa_r.dx_neg) begin
      z_nxt = HALF + a_r;
    end else begin
      z_nxt = '0 - a_r;
    end
  end

  // Round half up; a full turn wraps to zero with the carry.
  assign zsum        = z_r + RND;
  assign bearing_nxt = zsum[TB-1 -: ANGLE_WIDTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ena) begin
        va_r <= in_valid;
      end
      if (enb) begin
        vb_r <= va_r;
      end
      if (enc) begin
        vc_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      a_r   <= a_nxt;
      csa_r <= in_case;
    end
    if (enb) begin
      z_r <= z_nxt;
    end
    if (enc) begin
      bearing_r <= bearing_nxt;
    end
  end

  assign out_valid   = vc_r;
  assign out_bearing = bearing_r;

endmodule

`default_nettype wire

// ===== rtl/core/bearing_angle_atan2.sv =====
// ---------------------------------------------------------------------------
// Bearing angle (full-circle atan2)
// Direction from an origin point to a target point as a binary angle.
// ---------------------------------------------------------------------------
// The core takes one point pair per clock, unless stalled, and returns the
// bearing of (target - origin) over a full turn, 0 on the +x axis and
// counter-clockwise positive, where 2^ANGLE_WIDTH is one turn. It is a fully
// pipelined datapath of two front-end stages, one normalizer stage per shift
// step, one stage per CORDIC micro-rotation and three back-end stages ending
// in the output register. Sustained rate is one item per cycle; each stage
// holds its item while the next is full, so a stall at the output fills
// bubbles before the input is stalled. Identical points give 0; vertical and
// horizontal differences give exact zero, quarter, half and three-quarter turns.
`default_nettype none

`include "bearing_angle_atan2_defines.svh"

module bearing_angle_atan2 #(
  parameter int COORD_WIDTH   = bat_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = bat_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = bat_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_target_y,
  input  logic signed [COORD_WIDTH-1:0] in_target_x,
  input  logic signed [COORD_WIDTH-1:0] in_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_origin_x,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ANGLE_WIDTH-1:0]        out_bearing
);

  logic                   in_ready;
  logic                   f_valid, f_ready;
  logic [COORD_WIDTH-1:0] f_ax, f_ay;
  bat_pkg::bat_case_t     f_case;
  logic                   n_valid, n_ready;
  logic [COORD_WIDTH-1:0] n_ax, n_ay;
  bat_pkg::bat_case_t     n_case;
  logic                   c_valid, c_ready;
  bat_pkg::turn_t         c_z;
  bat_pkg::bat_case_t     c_case;

  assign in_stall = !in_ready;

  bat_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .target_y (in_target_y),
    .target_x (in_target_x),
    .origin_y (in_origin_y),
    .origin_x (in_origin_x),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_ax   (f_ax),
    .out_ay   (f_ay),
    .out_case (f_case)
  );

  bat_norm #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_ax    (f_ax),
    .in_ay    (f_ay),
    .in_case  (f_case),
    .out_valid(n_valid),
    .out_ready(n_ready),
    .out_ax   (n_ax),
    .out_ay   (n_ay),
    .out_case (n_case)
  );

  bat_cordic #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (n_valid),
    .in_ready (n_ready),
    .in_ax    (n_ax),
    .in_ay    (n_ay),
    .in_case  (n_case),
    .out_valid(c_valid),
    .out_ready(c_ready),
    .out_z    (c_z),
    .out_case (c_case)
  );

  bat_back #(
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (c_valid),
    .in_ready   (c_ready),
    .in_z       (c_z),
    .in_case    (c_case),
    .out_valid  (out_valid),
    .out_ready  (!out_stall),
    .out_bearing(out_bearing)
  );

  // A free output side lets every stage advance, so the input is never held.
  `BAT_ASSERT_IMP(a_free_output_no_stall, clk, rst_n, (!out_valid || !out_stall), !in_stall, "input stalled while the output side is free")
  // The input is held only when every section is full and the output is stalled.
  `BAT_ASSERT_IMP(a_stall_means_full, clk, rst_n, in_stall, (f_valid && n_valid && c_valid && out_valid && out_stall), "input stalled with a bubble in the pipeline")
  // A held input means the front end keeps its finished item.
  `BAT_ASSERT_NXT(a_front_keeps_item, clk, rst_n, in_stall, f_valid, "front end item lost during a stall")

endmodule

`default_nettype wire
